FILE: hw/rtl/pn2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pn2d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int COORD_W    = 24;
    localparam int LOAD_W     = 8;
    localparam int VAL_W      = 8;
    localparam int OUT_W      = 19;

    localparam int FP_ONE  = 2 ** FRAC_BITS;
    localparam int FP_HALF = 2 ** (FRAC_BITS - 1);

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int A_W   = FRAC_BITS + 2;
    localparam int G_W   = FRAC_BITS + 3;
    localparam int D_W   = FRAC_BITS + 4;
    localparam int L_W   = FRAC_BITS + 5;
    localparam int E_W   = FRAC_BITS + 6;

    localparam int STAGES   = 8;
    localparam int STG_IN   = 0;
    localparam int STG_HASH = 1;
    localparam int STG_GRAD = 2;
    localparam int STG_FADE = 3;
    localparam int STG_LERP = 4;
    localparam int STG_DIFF = 5;
    localparam int STG_MIX  = 6;
    localparam int STG_OUT  = 7;

    typedef enum logic {
        CMD_EVAL = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef logic [STAGES-1:0]    adv_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [ONE_W-1:0]     fade_t;

    function automatic logic signed [G_W-1:0] grad(
        input logic [2:0]            h,
        input logic signed [A_W-1:0] a,
        input logic signed [A_W-1:0] b
    );
        logic signed [G_W-1:0] u;
        logic signed [G_W-1:0] v;
        logic signed [G_W-1:0] su;
        logic signed [G_W-1:0] sv;
        u  = h[2] ? G_W'(b) : G_W'(a);
        v  = h[2] ? G_W'(a) : G_W'(b);
        su = h[0] ? -u : u;
        sv = h[1] ? -(v <<< 1) : (v <<< 1);
        return su + sv;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pn2d_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pn2d_req_if;
    import pn2d_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [LOAD_W-1:0]  load_index;
    logic [VAL_W-1:0]   load_value;

    modport source (
        output valid,
        output cmd,
        output x_coord,
        output y_coord,
        output load_index,
        output load_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  x_coord,
        input  y_coord,
        input  load_index,
        input  load_value,
        output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/pn2d_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pn2d_rsp_if;
    import pn2d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (
        output valid,
        output noise_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  noise_value,
        output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/pn2d_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module pn2d_hash (
    input  logic                        clk,
    input  pn2d_pkg::adv_t              adv,
    input  logic                        we,
    input  logic [pn2d_pkg::IDX_W-1:0]  wr_index,
    input  logic [pn2d_pkg::VAL_W-1:0]  wr_value,
    input  logic [pn2d_pkg::IDX_W-1:0]  xi,
    input  logic [pn2d_pkg::IDX_W-1:0]  yi,
    output logic [pn2d_pkg::VAL_W-1:0]  aa,
    output logic [pn2d_pkg::VAL_W-1:0]  ab,
    output logic [pn2d_pkg::VAL_W-1:0]  ba,
    output logic [pn2d_pkg::VAL_W-1:0]  bb
);
    import pn2d_pkg::*;

    // Three copies of the table, each written by every load, give six reads per beat.
    logic [VAL_W-1:0] perm_a_mem [TABLE_SIZE];
    logic [VAL_W-1:0] perm_b_mem [TABLE_SIZE];
    logic [VAL_W-1:0] perm_c_mem [TABLE_SIZE];

    logic [IDX_W-1:0] xn;
    logic [IDX_W-1:0] addr_aa;
    logic [IDX_W-1:0] addr_ab;
    logic [IDX_W-1:0] addr_ba;
    logic [IDX_W-1:0] addr_bb;
    logic [VAL_W-1:0] pa_reg;
    logic [VAL_W-1:0] pb_reg;
    logic [VAL_W-1:0] aa_reg;
    logic [VAL_W-1:0] ab_reg;
    logic [VAL_W-1:0] ba_reg;
    logic [VAL_W-1:0] bb_reg;

    always_comb
    begin
        xn      = IDX_W'(32'(xi) + 32'd1);
        addr_aa = IDX_W'(32'(pa_reg) + 32'(yi));
        addr_ab = IDX_W'(32'(pa_reg) + 32'(yi) + 32'd1);
        addr_ba = IDX_W'(32'(pb_reg) + 32'(yi));
        addr_bb = IDX_W'(32'(pb_reg) + 32'(yi) + 32'd1);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_a_mem[wr_index] <= wr_value;
        end
        if (adv[STG_IN])
        begin
            pa_reg <= perm_a_mem[xi];
            pb_reg <= perm_a_mem[xn];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_b_mem[wr_index] <= wr_value;
        end
        if (adv[STG_HASH])
        begin
            aa_reg <= perm_b_mem[addr_aa];
            ab_reg <= perm_b_mem[addr_ab];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_c_mem[wr_index] <= wr_value;
        end
        if (adv[STG_HASH])
        begin
            ba_reg <= perm_c_mem[addr_ba];
            bb_reg <= perm_c_mem[addr_bb];
        end
    end

    assign aa = aa_reg;
    assign ab = ab_reg;
    assign ba = ba_reg;
    assign bb = bb_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pn2d_fade.sv
`timescale 1ns / 1ps
`default_nettype none

module pn2d_fade (
    input  logic            clk,
    input  pn2d_pkg::adv_t  adv,
    input  pn2d_pkg::frac_t t,
    output pn2d_pkg::fade_t fade
);
    import pn2d_pkg::*;

    localparam int SQP_W = 2 * FRAC_BITS + 1;
    localparam int T3P_W = ONE_W + FRAC_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 6;
    localparam int QU_W  = FRAC_BITS + 5;
    localparam int RP_W  = ONE_W + QU_W + 1;
    localparam int RS_W  = RP_W - FRAC_BITS;

    logic [SQP_W-1:0]      sq_prod;
    fade_t                 sq_next;
    fade_t                 sq_reg;
    frac_t                 t_reg;
    logic [T3P_W-1:0]      t3_prod;
    fade_t                 t3_next;
    fade_t                 t3_reg;
    logic signed [Q_W-1:0] q_sum;
    logic [QU_W-1:0]       q_next;
    logic [QU_W-1:0]       q_reg;
    logic [RP_W-1:0]       r_prod;
    logic [RS_W-1:0]       r_scaled;
    fade_t                 fade_next;
    fade_t                 fade_reg;

    always_comb
    begin
        sq_prod = SQP_W'(t) * SQP_W'(t);
        sq_next = ONE_W'((sq_prod + SQP_W'(FP_HALF)) >> FRAC_BITS);

        t3_prod = T3P_W'(sq_reg) * T3P_W'(t_reg);
        t3_next = ONE_W'((t3_prod + T3P_W'(FP_HALF)) >> FRAC_BITS);
        q_sum   = $signed(Q_W'(sq_reg) * Q_W'(6) - Q_W'(t_reg) * Q_W'(15)
                          + Q_W'(10 * FP_ONE));
        q_next  = q_sum[Q_W-1] ? '0 : q_sum[QU_W-1:0];

        r_prod   = RP_W'(t3_reg) * RP_W'(q_reg);
        r_scaled = RS_W'((r_prod + RP_W'(FP_HALF)) >> FRAC_BITS);
        if (r_scaled > RS_W'(FP_ONE))
        begin
            fade_next = fade_t'(FP_ONE);
        end
        else
        begin
            fade_next = r_scaled[ONE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_HASH])
        begin
            sq_reg <= sq_next;
            t_reg  <= t;
        end
        if (adv[STG_GRAD])
        begin
            t3_reg <= t3_next;
            q_reg  <= q_next;
        end
        if (adv[STG_FADE])
        begin
            fade_reg <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pn2d_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module pn2d_blend (
    input  logic                           clk,
    input  pn2d_pkg::adv_t                 adv,
    input  pn2d_pkg::frac_t                xf,
    input  pn2d_pkg::frac_t                yf,
    input  logic [pn2d_pkg::VAL_W-1:0]     aa,
    input  logic [pn2d_pkg::VAL_W-1:0]     ab,
    input  logic [pn2d_pkg::VAL_W-1:0]     ba,
    input  logic [pn2d_pkg::VAL_W-1:0]     bb,
    input  pn2d_pkg::fade_t                fu,
    input  pn2d_pkg::fade_t                fv,
    output logic signed [pn2d_pkg::OUT_W-1:0] noise_value
);
    import pn2d_pkg::*;

    localparam int P1_W = ONE_W + 1 + D_W;
    localparam int P2_W = ONE_W + 1 + E_W;
    localparam int M_W  = E_W + 2;
    localparam logic signed [M_W-1:0] SAT_HI = M_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [M_W-1:0] SAT_LO = M_W'(-(2 ** (OUT_W - 1)));

    frac_t                   xf_reg;
    frac_t                   yf_reg;
    logic signed [G_W-1:0]   g00_next;
    logic signed [G_W-1:0]   g10_next;
    logic signed [G_W-1:0]   g01_next;
    logic signed [G_W-1:0]   g11_next;
    logic signed [G_W-1:0]   g00_reg;
    logic signed [G_W-1:0]   g10_reg;
    logic signed [G_W-1:0]   g01_reg;
    logic signed [G_W-1:0]   g11_reg;
    logic signed [D_W-1:0]   d1_next;
    logic signed [D_W-1:0]   d2_next;
    logic signed [D_W-1:0]   d1_reg;
    logic signed [D_W-1:0]   d2_reg;
    logic signed [G_W-1:0]   g00_d_reg;
    logic signed [G_W-1:0]   g01_d_reg;
    logic signed [P1_W-1:0]  prod1;
    logic signed [P1_W-1:0]  prod2;
    logic [P1_W:0]           acc1;
    logic [P1_W:0]           acc2;
    logic signed [P1_W:0]    sh1;
    logic signed [P1_W:0]    sh2;
    logic signed [L_W-1:0]   x1_next;
    logic signed [L_W-1:0]   x2_next;
    logic signed [L_W-1:0]   x1_reg;
    logic signed [L_W-1:0]   x2_reg;
    fade_t                   fv_l_reg;
    logic signed [E_W-1:0]   d3_next;
    logic signed [E_W-1:0]   d3_reg;
    logic signed [L_W-1:0]   x1_d_reg;
    fade_t                   fv_d_reg;
    logic signed [P2_W-1:0]  prod3;
    logic [P2_W:0]           acc3;
    logic signed [P2_W:0]    sh3;
    logic signed [E_W-1:0]   n_next;
    logic signed [E_W-1:0]   n_reg;
    logic signed [M_W-1:0]   m;
    logic signed [M_W-1:0]   m_rnd;
    logic signed [M_W-1:0]   m_half;
    logic signed [OUT_W-1:0] out_next;
    logic signed [OUT_W-1:0] out_reg;

    // Offsets toward the far corner are the fraction minus one, i.e. the fraction
    // with the two sign bits set.
    always_comb
    begin
        g00_next = grad(aa[2:0], {2'b00, xf_reg}, {2'b00, yf_reg});
        g10_next = grad(ba[2:0], {2'b11, xf_reg}, {2'b00, yf_reg});
        g01_next = grad(ab[2:0], {2'b00, xf_reg}, {2'b11, yf_reg});
        g11_next = grad(bb[2:0], {2'b11, xf_reg}, {2'b11, yf_reg});

        d1_next = D_W'(g10_reg) - D_W'(g00_reg);
        d2_next = D_W'(g11_reg) - D_W'(g01_reg);

        // Products are rounded to nearest with ties away from zero.
        prod1   = $signed({1'b0, fu}) * d1_reg;
        prod2   = $signed({1'b0, fu}) * d2_reg;
        acc1    = (P1_W + 1)'(prod1) + (P1_W + 1)'(FP_HALF) - (P1_W + 1)'(prod1[P1_W-1]);
        acc2    = (P1_W + 1)'(prod2) + (P1_W + 1)'(FP_HALF) - (P1_W + 1)'(prod2[P1_W-1]);
        sh1     = $signed(acc1) >>> FRAC_BITS;
        sh2     = $signed(acc2) >>> FRAC_BITS;
        x1_next = L_W'(g00_d_reg) + L_W'(sh1);
        x2_next = L_W'(g01_d_reg) + L_W'(sh2);

        d3_next = E_W'(x2_reg) - E_W'(x1_reg);

        prod3  = $signed({1'b0, fv_d_reg}) * d3_reg;
        acc3   = (P2_W + 1)'(prod3) + (P2_W + 1)'(FP_HALF) - (P2_W + 1)'(prod3[P2_W-1]);
        sh3    = $signed(acc3) >>> FRAC_BITS;
        n_next = E_W'(x1_d_reg) + E_W'(sh3);

        m      = M_W'(n_reg) + M_W'(FP_ONE);
        m_rnd  = m + (m[M_W-1] ? M_W'(0) : M_W'(1));
        m_half = m_rnd >>> 1;
        if (m_half > SAT_HI)
        begin
            out_next = OUT_W'(SAT_HI);
        end
        else if (m_half < SAT_LO)
        begin
            out_next = OUT_W'(SAT_LO);
        end
        else
        begin
            out_next = m_half[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_HASH])
        begin
            xf_reg <= xf;
            yf_reg <= yf;
        end
        if (adv[STG_GRAD])
        begin
            g00_reg <= g00_next;
            g10_reg <= g10_next;
            g01_reg <= g01_next;
            g11_reg <= g11_next;
        end
        if (adv[STG_FADE])
        begin
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            g00_d_reg <= g00_reg;
            g01_d_reg <= g01_reg;
        end
        if (adv[STG_LERP])
        begin
            x1_reg   <= x1_next;
            x2_reg   <= x2_next;
            fv_l_reg <= fv;
        end
        if (adv[STG_DIFF])
        begin
            d3_reg   <= d3_next;
            x1_d_reg <= x1_reg;
            fv_d_reg <= fv_l_reg;
        end
        if (adv[STG_MIX])
        begin
            n_reg <= n_next;
        end
        if (adv[STG_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/perlin_noise_2d_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-dimensional gradient noise engine. Each request beat is either a table load or an
// evaluation; the block takes one beat per clock unless the pipeline is stalled, and an
// evaluation result passes the stage registers STG_IN to STG_OUT and is held in the
// output register on the response channel. The eight pipeline stages each load only when
// they are empty or the stage after them is moving, so a stalled response keeps taking
// requests until the pipeline is full. Loads produce no response; they write all three
// copies of the 256-entry permutation table in the cycle they are taken, and each copy
// serves two reads per cycle, which sets the rate of one evaluation per clock while
// nothing stalls. Reset does not clear the table: every entry an evaluation can reach must be loaded first.
module perlin_noise_2d_core (
    input  logic              clk,
    input  logic              rst_n,
    pn2d_req_if.sink          req,
    pn2d_rsp_if.source        rsp
);
    import pn2d_pkg::*;

    adv_t             adv;
    adv_t             valid_reg;
    adv_t             valid_next;
    logic             accept;
    logic             load_we;
    logic             eval_in;
    frac_t            xf_reg;
    frac_t            yf_reg;
    logic [IDX_W-1:0] yi_reg;
    logic [VAL_W-1:0] aa;
    logic [VAL_W-1:0] ab;
    logic [VAL_W-1:0] ba;
    logic [VAL_W-1:0] bb;
    fade_t            fu;
    fade_t            fv;

    always_comb
    begin
        adv[STG_OUT] = !valid_reg[STG_OUT] || rsp.ready;
        for (int k = STG_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end

        accept  = req.valid && adv[STG_IN];
        load_we = accept && (req.cmd == CMD_LOAD);
        eval_in = accept && (req.cmd == CMD_EVAL);

        valid_next = valid_reg;
        if (adv[STG_IN])
        begin
            valid_next[STG_IN] = eval_in;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_IN])
        begin
            xf_reg <= req.x_coord[FRAC_BITS-1:0];
            yf_reg <= req.y_coord[FRAC_BITS-1:0];
            yi_reg <= req.y_coord[FRAC_BITS +: IDX_W];
        end
    end

    assign req.ready = adv[STG_IN];
    assign rsp.valid = valid_reg[STG_OUT];

    pn2d_hash u_hash (
        .clk      (clk),
        .adv      (adv),
        .we       (load_we),
        .wr_index (req.load_index[IDX_W-1:0]),
        .wr_value (req.load_value),
        .xi       (req.x_coord[FRAC_BITS +: IDX_W]),
        .yi       (yi_reg),
        .aa       (aa),
        .ab       (ab),
        .ba       (ba),
        .bb       (bb)
    );

    pn2d_fade u_fade_x (
        .clk  (clk),
        .adv  (adv),
        .t    (xf_reg),
        .fade (fu)
    );

    pn2d_fade u_fade_y (
        .clk  (clk),
        .adv  (adv),
        .t    (yf_reg),
        .fade (fv)
    );

    pn2d_blend u_blend (
        .clk         (clk),
        .adv         (adv),
        .xf          (xf_reg),
        .yf          (yf_reg),
        .aa          (aa),
        .ab          (ab),
        .ba          (ba),
        .bb          (bb),
        .fu          (fu),
        .fv          (fv),
        .noise_value (rsp.noise_value)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/pn2d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pn2d_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           in_cmd,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [pn2d_pkg::OUT_W-1:0]     out_value
);
    import pn2d_pkg::*;

    localparam int CNT_W = $clog2(STAGES + 1) + 1;

    logic             eval_beat;
    logic             out_beat;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;

    always_comb
    begin
        eval_beat = in_valid && in_ready && (in_cmd == CMD_EVAL);
        out_beat  = out_valid && out_ready;
        pend_next = pend_reg + CNT_W'(eval_beat) - CNT_W'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("response changed while stalled");

    a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("response beat without an outstanding evaluation");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(STAGES))
        else $error("more evaluations in flight than pipeline stages");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request side stalled with an empty response register");

endmodule

bind perlin_noise_2d_core pn2d_checker u_pn2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_value (rsp.noise_value)
);

`default_nettype wire

FILE: tb/tb_perlin_noise_2d_core.sv
`timescale 1ns / 1ps

module tb_perlin_noise_2d_core;
    import pn2d_pkg::*;

    localparam int NUM_DIRECTED   = 18;
    localparam int NUM_RANDOM     = 1180;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * STAGES;

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic signed [OUT_W-1:0] noise_t;

    typedef struct {
        cmd_t              op;
        coord_t            xc;
        coord_t            yc;
        logic [LOAD_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        bit                known_ok;
        noise_t            known;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pn2d_req_if req_if ();
    pn2d_rsp_if rsp_if ();

    perlin_noise_2d_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [VAL_W-1:0] perm_copy [TABLE_SIZE];
    logic [VAL_W-1:0] perm_init [TABLE_SIZE];
    noise_t           pending_noise [$];
    int               fail_count;
    int               idle_cycles;
    int               send_calm;
    int               stall_left;
    int               recv_calm;

    // Integer lattice points give zero noise, so they read back as one half.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_EVAL, 24'h000000, 24'h000000, 8'h00, 8'h00, 1'b1, 19'sd32768},
        '{CMD_EVAL, 24'h010000, 24'h020000, 8'h00, 8'h00, 1'b1, 19'sd32768},
        '{CMD_EVAL, 24'hFF0000, 24'hFF0000, 8'hFF, 8'hFF, 1'b1, 19'sd32768},
        '{CMD_EVAL, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h00FFFF, 24'h000000, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h000000, 24'h00FFFF, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h008000, 24'h008000, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h000001, 24'h000001, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_LOAD, 24'h000000, 24'h000000, 8'hFF, 8'hFF, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'hFF8000, 24'hFF8000, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_LOAD, 24'h000000, 24'h000000, 8'h00, 8'hFF, 1'b0, 19'sd0},
        '{CMD_LOAD, 24'h000000, 24'h000000, 8'hFF, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'hFF8000, 24'h007FFF, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'hAAAAAA, 24'h555555, 8'h55, 8'hAA, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h555555, 24'hAAAAAA, 8'hAA, 8'h55, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'h123456, 24'hABCDEF, 8'h00, 8'h00, 1'b0, 19'sd0},
        '{CMD_EVAL, 24'hFE0000, 24'h00FFFF, 8'h00, 8'h00, 1'b0, 19'sd0}
    };

    function automatic longint round_q(input longint p);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + FP_HALF) >> FRAC_BITS;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return round_q(a * b);
    endfunction

    function automatic longint fade_q(input longint t);
        longint sq;
        longint q;
        longint r;
        sq = mul_q(t, t);
        q  = 6 * sq - 15 * t + 10 * longint'(FP_ONE);
        if (q < 0)
            q = 0;
        r = mul_q(mul_q(sq, t), q);
        if (r < 0)
            r = 0;
        if (r > FP_ONE)
            r = FP_ONE;
        return r;
    endfunction

    function automatic longint blend_q(input longint t, input longint a, input longint b);
        return a + mul_q(t, b - a);
    endfunction

    function automatic longint corner_grad(input logic [VAL_W-1:0] hash, input longint a,
                                           input longint b);
        longint u;
        longint v;
        longint gu;
        longint gv;
        u  = hash[2] ? b : a;
        v  = hash[2] ? a : b;
        gu = hash[0] ? -u : u;
        gv = hash[1] ? -2 * v : 2 * v;
        return gu + gv;
    endfunction

    function automatic noise_t noise_at(input coord_t xc, input coord_t yc);
        logic [IDX_W-1:0] xi;
        logic [IDX_W-1:0] yi;
        logic [IDX_W-1:0] xn;
        logic [VAL_W-1:0] pa;
        logic [VAL_W-1:0] pb;
        logic [VAL_W-1:0] aa;
        logic [VAL_W-1:0] ab;
        logic [VAL_W-1:0] ba;
        logic [VAL_W-1:0] bb;
        longint           xf;
        longint           yf;
        longint           fu;
        longint           fv;
        longint           x1;
        longint           x2;
        longint           n;
        longint           m;
        longint           mag;
        longint           res;
        xi = IDX_W'(xc >> FRAC_BITS);
        yi = IDX_W'(yc >> FRAC_BITS);
        xn = IDX_W'(xi + 1);
        xf = longint'(xc[FRAC_BITS-1:0]);
        yf = longint'(yc[FRAC_BITS-1:0]);
        fu = fade_q(xf);
        fv = fade_q(yf);
        pa = perm_copy[xi];
        pb = perm_copy[xn];
        aa = perm_copy[IDX_W'(pa + yi)];
        ab = perm_copy[IDX_W'(pa + yi + 1)];
        ba = perm_copy[IDX_W'(pb + yi)];
        bb = perm_copy[IDX_W'(pb + yi + 1)];
        x1 = blend_q(fu, corner_grad(aa, xf, yf), corner_grad(ba, xf - FP_ONE, yf));
        x2 = blend_q(fu, corner_grad(ab, xf, yf - FP_ONE),
                     corner_grad(bb, xf - FP_ONE, yf - FP_ONE));
        n   = blend_q(fv, x1, x2);
        m   = n + FP_ONE;
        mag = (m < 0) ? -m : m;
        mag = (mag + 1) >> 1;
        res = (m < 0) ? -mag : mag;
        if (res > (longint'(1) << (OUT_W - 1)) - 1)
            res = (longint'(1) << (OUT_W - 1)) - 1;
        if (res < -(longint'(1) << (OUT_W - 1)))
            res = -(longint'(1) << (OUT_W - 1));
        return noise_t'(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic coord_t pick_coord();
        logic [FRAC_BITS-1:0] frac;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 4))
                    0: frac = '0;
                    1: frac = FRAC_BITS'(1);
                    2: frac = FRAC_BITS'(FP_HALF);
                    3: frac = FRAC_BITS'(FP_ONE - 2);
                    default: frac = '1;
                endcase
                return {8'($urandom_range(0, 255)), frac};
            end
            2:
                return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                        FRAC_BITS'($urandom_range(0, FP_ONE - 1))};
            default:
                return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        endcase
    endfunction

    task automatic send_beat(input cmd_t op, input coord_t xc, input coord_t yc,
                             input logic [LOAD_W-1:0] idx, input logic [VAL_W-1:0] val,
                             input bit known_ok, input noise_t known);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 149) == 0)
                send_calm = $urandom_range(40, 160);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= op;
        req_if.x_coord    <= xc;
        req_if.y_coord    <= yc;
        req_if.load_index <= idx;
        req_if.load_value <= val;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (op == CMD_LOAD)
            perm_copy[idx] = val;
        else
            pending_noise.push_back(known_ok ? known : noise_at(xc, yc));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        noise_t want;
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        recv_calm    = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_noise.size() == 0)
                begin
                    $error("noise_value: beat with nothing expected, actual %0d",
                           rsp_if.noise_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_noise.pop_front();
                    if (rsp_if.noise_value !== want)
                    begin
                        $error("noise_value mismatch: expected %0d, actual %0d",
                               want, rsp_if.noise_value);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 199) == 0)
                    recv_calm = $urandom_range(50, 200);
                else
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [VAL_W-1:0] tmp;
        int               j;
        bit               is_load;
        fail_count        = 0;
        send_calm         = 0;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_EVAL;
        req_if.x_coord    = '0;
        req_if.y_coord    = '0;
        req_if.load_index = '0;
        req_if.load_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table with a random permutation so that no evaluation can reach
        // an unwritten entry.
        for (int i = 0; i < TABLE_SIZE; i++)
            perm_init[i] = VAL_W'(i);
        for (int i = TABLE_SIZE - 1; i > 0; i--)
        begin
            j            = $urandom_range(0, i);
            tmp          = perm_init[i];
            perm_init[i] = perm_init[j];
            perm_init[j] = tmp;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
            send_beat(CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom), LOAD_W'(i),
                      perm_init[i], 1'b0, '0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].xc, directed_rows[i].yc,
                      directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].known_ok, directed_rows[i].known);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            is_load = ($urandom_range(0, 9) == 0);
            send_beat(is_load ? CMD_LOAD : CMD_EVAL, pick_coord(), pick_coord(),
                      LOAD_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)),
                      1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pn2d_pkg.sv
hw/rtl/pn2d_req_if.sv
hw/rtl/pn2d_rsp_if.sv
hw/rtl/pn2d_hash.sv
hw/rtl/pn2d_fade.sv
hw/rtl/pn2d_blend.sv
hw/rtl/perlin_noise_2d_core.sv
hw/rtl/pn2d_checker.sv
tb/tb_perlin_noise_2d_core.sv
